FILE: sv/ppiu_pkg.sv
package ppiu_pkg;

  localparam int WORD_BITS      = 64;
  localparam int MIN_FIELD_BITS = 4;
  localparam int SECTION_EDGE   = 16;
  localparam int LANES          = WORD_BITS / MIN_FIELD_BITS;
  localparam int LANE_IDX_BITS  = $clog2(LANES);
  localparam int WIDTH_BITS     = 5;
  localparam int SIZE_BITS      = 13;
  localparam int ENTRY_BITS     = 13;
  localparam int ENTRIES        = SECTION_EDGE * SECTION_EDGE * SECTION_EDGE;
  localparam int INDEX_BITS     = 12;
  localparam int CHUNK_BITS     = 22;
  localparam int WORLD_BITS     = 26;
  localparam int SEC_Y_BITS     = 4;
  localparam int WORLD_Y_BITS   = 8;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_CHUNK_X = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHUNK_Z = 1'd1;

  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef struct packed {
    logic                  keep;
    logic [INDEX_BITS-1:0] index;
  } lane_res_t;

  // Bit length of (size - 1), clamped to [MIN_FIELD_BITS, max_bits].
  function automatic width_t field_width(input logic [SIZE_BITS-1:0] size,
                                         input width_t max_bits);
    logic [SIZE_BITS-1:0] v;
    width_t               bits;
    v    = (size == '0) ? '0 : size - 1'b1;
    bits = '0;
    for (int i = 0; i < SIZE_BITS; i++) begin
      if (v[i]) begin
        bits = width_t'(i + 1);
      end
    end
    if (bits < width_t'(MIN_FIELD_BITS)) begin
      bits = width_t'(MIN_FIELD_BITS);
    end
    if (bits > max_bits) begin
      bits = max_bits;
    end
    return bits;
  endfunction

  // Fields that fit in one word at a given width.
  function automatic width_t fields_per_word(input width_t w);
    width_t n;
    case (w)
      5'd4:  n = width_t'(WORD_BITS / 4);
      5'd5:  n = width_t'(WORD_BITS / 5);
      5'd6:  n = width_t'(WORD_BITS / 6);
      5'd7:  n = width_t'(WORD_BITS / 7);
      5'd8:  n = width_t'(WORD_BITS / 8);
      5'd9:  n = width_t'(WORD_BITS / 9);
      5'd10: n = width_t'(WORD_BITS / 10);
      5'd11: n = width_t'(WORD_BITS / 11);
      5'd12: n = width_t'(WORD_BITS / 12);
      5'd13: n = width_t'(WORD_BITS / 13);
      5'd14: n = width_t'(WORD_BITS / 14);
      5'd15: n = width_t'(WORD_BITS / 15);
      5'd16: n = width_t'(WORD_BITS / 16);
      default: n = width_t'(WORD_BITS / 16);
    endcase
    return n;
  endfunction

endpackage

FILE: sv/ppiu_lane.sv
module ppiu_lane #(
  parameter int K              = 0,
  parameter int MAX_FIELD_BITS = 12
) (
  input  logic [ppiu_pkg::WORD_BITS-1:0] word,
  input  ppiu_pkg::width_t               width,
  input  ppiu_pkg::width_t               count,
  input  logic [ppiu_pkg::SIZE_BITS-1:0] palette_size,
  input  ppiu_pkg::entry_t               base,
  output ppiu_pkg::lane_res_t            res
);

  localparam int CMP_BITS = (MAX_FIELD_BITS > ppiu_pkg::SIZE_BITS) ?
                            MAX_FIELD_BITS : ppiu_pkg::SIZE_BITS;

  logic [ppiu_pkg::WORD_BITS-1:0] shifted;
  logic [MAX_FIELD_BITS-1:0]      field;
  ppiu_pkg::entry_t               num;

  // Select this lane's bit offset for the active width.
  always_comb begin
    shifted = '0;
    for (int ww = ppiu_pkg::MIN_FIELD_BITS; ww <= MAX_FIELD_BITS; ww++) begin
      if (width == ppiu_pkg::width_t'(ww)) begin
        shifted = word >> (K * ww);
      end
    end
  end

  assign field = shifted[MAX_FIELD_BITS-1:0] & ~({MAX_FIELD_BITS{1'b1}} << width);
  assign num   = base + ppiu_pkg::entry_t'(K);

  assign res.keep  = (ppiu_pkg::width_t'(K) < count) && !num[ppiu_pkg::ENTRY_BITS-1] &&
                     (CMP_BITS'(field) < CMP_BITS'(palette_size));
  assign res.index = ppiu_pkg::INDEX_BITS'(field);

endmodule

FILE: sv/ppiu_merge.sv
module ppiu_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  ppiu_pkg::lane_res_t                    lane_res [ppiu_pkg::LANES],
  input  ppiu_pkg::entry_t                       base,
  input  logic [ppiu_pkg::SEC_Y_BITS-1:0]        section_y,
  input  logic signed [ppiu_pkg::CHUNK_BITS-1:0] chunk_x,
  input  logic signed [ppiu_pkg::CHUNK_BITS-1:0] chunk_z,
  output logic                                   idle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ppiu_pkg::WORLD_BITS-1:0] world_x,
  output logic [ppiu_pkg::WORLD_Y_BITS-1:0]      world_y,
  output logic signed [ppiu_pkg::WORLD_BITS-1:0] world_z,
  output logic [ppiu_pkg::INDEX_BITS-1:0]        palette_index,
  output logic                                   last
);

  logic [ppiu_pkg::LANES-1:0]      mask;
  logic [ppiu_pkg::LANES-1:0]      pick;
  logic [ppiu_pkg::LANES-1:0]      rest;
  logic [ppiu_pkg::INDEX_BITS-1:0] idx [ppiu_pkg::LANES];
  ppiu_pkg::entry_t                item_base;
  logic [ppiu_pkg::SEC_Y_BITS-1:0] item_y;
  logic [ppiu_pkg::LANE_IDX_BITS-1:0] sel;
  ppiu_pkg::entry_t                num;
  logic                            pop;

  assign idle = (mask == '0);
  assign pick = mask & (~mask + 1'b1);
  assign rest = mask & ~pick;
  assign pop  = !idle && (!out_valid || out_ready);
  assign num  = item_base + ppiu_pkg::entry_t'(sel);

  // Lowest surviving lane goes first to keep packing order.
  always_comb begin
    sel = '0;
    for (int i = ppiu_pkg::LANES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = ppiu_pkg::LANE_IDX_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < ppiu_pkg::LANES; i++) begin
          mask[i] <= lane_res[i].keep;
        end
      end else if (pop) begin
        mask <= rest;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < ppiu_pkg::LANES; i++) begin
        idx[i] <= lane_res[i].index;
      end
      item_base <= base;
      item_y    <= section_y;
    end
    if (pop) begin
      // chunk * 16 leaves the low nibble free for the local coordinate.
      world_x       <= {chunk_x, num[3:0]};
      world_z       <= {chunk_z, num[7:4]};
      world_y       <= {item_y, num[11:8]};
      palette_index <= idx[sel];
      last          <= (rest == '0);
    end
  end

endmodule

FILE: sv/packed_palette_index_unpacker.sv
// Packed palette index unpacker. Each input transfer carries one 64-bit word
// of a section's packed palette indices; sixteen lanes pull every field of the
// word apart in the accept cycle and flag the ones that survive (index below
// the palette size, entry number below 4096). The merge stage then hands out
// one surviving field per cycle in packing order while the output is not stalled,
// with world coordinates, and marks the word's final result with tlast. The block
// takes no new word until every surviving field of the current one (at most 16)
// has moved into the output register. The output register lets the next word be
// accepted while the final result of the previous one waits to be taken. Write
// chunk_x and chunk_z only while idle.
module packed_palette_index_unpacker #(
  parameter int MAX_FIELD_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [21:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // section_y[3:0], palette_size[16:4], packed_word[80:17]
  input  logic [0:0]  s_tuser,  // section_start[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // world_x[25:0], world_y[33:26], world_z[59:34],
                                // palette_index[71:60]
  output logic        m_tlast
);

  logic [ppiu_pkg::SEC_Y_BITS-1:0]        section_y;
  logic [ppiu_pkg::SIZE_BITS-1:0]         palette_size;
  logic [ppiu_pkg::WORD_BITS-1:0]         packed_word;
  logic                                   section_start;
  logic signed [ppiu_pkg::CHUNK_BITS-1:0] chunk_x;
  logic signed [ppiu_pkg::CHUNK_BITS-1:0] chunk_z;
  ppiu_pkg::entry_t                       entry_index;
  ppiu_pkg::entry_t                       entry_index_next;
  ppiu_pkg::entry_t                       base;
  ppiu_pkg::width_t                       width;
  ppiu_pkg::width_t                       count;
  ppiu_pkg::lane_res_t                    lane_res [ppiu_pkg::LANES];
  logic [ppiu_pkg::ENTRY_BITS:0]          sum;
  logic                                   accept;
  logic                                   idle;
  logic signed [ppiu_pkg::WORLD_BITS-1:0] world_x;
  logic signed [ppiu_pkg::WORLD_BITS-1:0] world_z;
  logic [ppiu_pkg::WORLD_Y_BITS-1:0]      world_y;
  logic [ppiu_pkg::INDEX_BITS-1:0]        palette_index;

  assign section_y     = s_tdata[3:0];
  assign palette_size  = s_tdata[16:4];
  assign packed_word   = s_tdata[80:17];
  assign section_start = s_tuser[0];

  assign s_tready = idle;
  assign accept   = s_tvalid && s_tready;

  assign width = ppiu_pkg::field_width(palette_size, ppiu_pkg::width_t'(MAX_FIELD_BITS));
  assign count = ppiu_pkg::fields_per_word(width);
  assign base  = section_start ? '0 : entry_index;
  assign sum   = {1'b0, base} + (ppiu_pkg::ENTRY_BITS + 1)'(count);

  // Saturate at one past the last entry until the next section starts.
  assign entry_index_next = (sum > (ppiu_pkg::ENTRY_BITS + 1)'(ppiu_pkg::ENTRIES)) ?
                            ppiu_pkg::entry_t'(ppiu_pkg::ENTRIES) :
                            sum[ppiu_pkg::ENTRY_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x     <= '0;
      chunk_z     <= '0;
      entry_index <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppiu_pkg::REG_CHUNK_X: chunk_x <= cfg_data;
          ppiu_pkg::REG_CHUNK_Z: chunk_z <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        entry_index <= entry_index_next;
      end
    end
  end

  for (genvar k = 0; k < ppiu_pkg::LANES; k++) begin : g_lane
    ppiu_lane #(
      .K              (k),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_lane (
      .word         (packed_word),
      .width        (width),
      .count        (count),
      .palette_size (palette_size),
      .base         (base),
      .res          (lane_res[k])
    );
  end

  ppiu_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .lane_res      (lane_res),
    .base          (base),
    .section_y     (section_y),
    .chunk_x       (chunk_x),
    .chunk_z       (chunk_z),
    .idle          (idle),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .world_x       (world_x),
    .world_y       (world_y),
    .world_z       (world_z),
    .palette_index (palette_index),
    .last          (m_tlast)
  );

  assign m_tdata = {palette_index, world_z, world_y, world_x};

endmodule

FILE: sv/ppiu_checker.sv
module ppiu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  // More results of the same word are still pending, so no new word.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input accepted while a word still has results pending");

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped before transfer");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

endmodule

bind packed_palette_index_unpacker ppiu_checker u_ppiu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

FILE: test/packed_palette_index_unpacker_tb.sv
module packed_palette_index_unpacker_tb;

  localparam int FIELD_CAP      = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [3:0]  section_y;
    logic [12:0] palette_size;
    logic        section_start;
    logic [63:0] packed_word;
  } word_item_t;

  typedef struct packed {
    logic signed [25:0] world_x;
    logic [7:0]         world_y;
    logic signed [25:0] world_z;
    logic [11:0]        palette_index;
    logic               last;
  } block_res_t;

  // How a directed row is checked: by the predictor, by the typed-in single result, or as giving no result.
  typedef enum logic [1:0] {
    CHECK_PREDICT,
    CHECK_SILENT,
    CHECK_SINGLE
  } check_kind_t;

  typedef struct packed {
    word_item_t  item;
    check_kind_t kind;
    block_res_t  res;
  } dir_row_t;

  localparam block_res_t NO_RES = '0;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [21:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata   = '0;  // section_y[3:0], palette_size[16:4], packed_word[80:17]
  logic [0:0]  s_tuser   = '0;  // section_start[0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [71:0] m_tdata;         // world_x[25:0], world_y[33:26], world_z[59:34],
                                // palette_index[71:60]
  logic        m_tlast;

  logic signed [21:0] chunk_x = '0;
  logic signed [21:0] chunk_z = '0;
  int                 section_entry = 0;
  block_res_t         pending_blocks[$];
  int                 mismatches = 0;
  logic               calm = 1'b0;
  block_res_t         seen_res;
  block_res_t         want_res;
  int                 stall_cycles;
  dir_row_t           dir_rows [0:21];

  packed_palette_index_unpacker #(
    .MAX_FIELD_BITS(FIELD_CAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int field_bits(input logic [12:0] psize);
    logic [12:0] span;
    int          bits;
    span = (psize == 13'd0) ? 13'd0 : psize - 13'd1;
    bits = ppiu_pkg::MIN_FIELD_BITS;
    for (int b = 0; b < ppiu_pkg::SIZE_BITS; b++) begin
      if (span[b] && b + 1 > bits) begin
        bits = b + 1;
      end
    end
    return (bits > FIELD_CAP) ? FIELD_CAP : bits;
  endfunction

  // Append the block results of one word and advance the entry count.
  task automatic unpack_word(input word_item_t it);
    int          width;
    int          count;
    int          mark;
    logic [12:0] num;
    logic [63:0] fmask;
    logic [63:0] pid;
    block_res_t  r;
    width = field_bits(it.palette_size);
    count = ppiu_pkg::WORD_BITS / width;
    fmask = (64'd1 << width) - 64'd1;
    mark  = pending_blocks.size();
    if (it.section_start) begin
      section_entry = 0;
    end
    for (int k = 0; k < count; k++) begin
      if (section_entry + k >= ppiu_pkg::ENTRIES) begin
        break;
      end
      pid = (it.packed_word >> (k * width)) & fmask;
      if (pid >= 64'(it.palette_size)) begin
        continue;
      end
      num = 13'(section_entry + k);
      // chunk*16 + local keeps the local part in the low four bits
      r.world_x       = {chunk_x, num[3:0]};
      r.world_y       = {it.section_y, num[11:8]};
      r.world_z       = {chunk_z, num[7:4]};
      r.palette_index = pid[11:0];
      r.last          = 1'b0;
      pending_blocks  = {pending_blocks, r};
    end
    if (pending_blocks.size() > mark) begin
      pending_blocks[pending_blocks.size() - 1].last = 1'b1;
    end
    section_entry = (section_entry + count > ppiu_pkg::ENTRIES) ? ppiu_pkg::ENTRIES :
                    section_entry + count;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [12:0] pick_size();
    int r;
    int e;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 13'd0;
    end
    if (r < 13) begin
      return 13'($urandom_range(4097, 8191));
    end
    e = $urandom_range(0, 12);
    return 13'($urandom_range((e == 0) ? 1 : (1 << (e - 1)) + 1, 1 << e));
  endfunction

  function automatic logic [63:0] make_word(input logic [12:0] psize);
    int          w;
    int          cap;
    int          mode;
    logic [63:0] wd;
    logic [63:0] mask;
    logic [63:0] fld;
    w    = field_bits(psize);
    mode = $urandom_range(0, 9);
    wd   = {$urandom, $urandom};
    if (mode == 3) begin
      wd = '0;
    end else if (mode == 4) begin
      wd = '1;
    end else if (mode > 4) begin
      // fill every field with an index that survives the bound check unless the palette size is zero
      cap  = (psize == 13'd0) ? 0 : ((psize > 13'd4096) ? 4095 : int'(psize) - 1);
      mask = (64'd1 << w) - 64'd1;
      for (int k = 0; k < ppiu_pkg::WORD_BITS / w; k++) begin
        fld = 64'($urandom_range(0, cap));
        wd  = (wd & ~(mask << (k * w))) | ((fld & mask) << (k * w));
      end
    end
    return wd;
  endfunction

  task automatic push_word(input word_item_t it, input check_kind_t kind,
                           input block_res_t typed);
    int gap;
    int mark;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, it.packed_word, it.palette_size, it.section_y};
    s_tuser  <= it.section_start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mark = pending_blocks.size();
    unpack_word(it);
    if (kind != CHECK_PREDICT) begin
      while (pending_blocks.size() > mark) void'(pending_blocks.pop_back());
      if (kind == CHECK_SINGLE) begin
        pending_blocks = {pending_blocks, typed};
      end
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_chunk(input logic [21:0] x, input logic [21:0] z);
    cfg_we    <= 1'b1;
    cfg_index <= ppiu_pkg::REG_CHUNK_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= ppiu_pkg::REG_CHUNK_Z;
    cfg_data  <= z;
    @(posedge clk);
    cfg_we  <= 1'b0;
    chunk_x = x;
    chunk_z = z;
  endtask

  task automatic play_section(input int words);
    word_item_t  it;
    logic [12:0] psize;
    logic [3:0]  sy;
    int          r;
    psize = pick_size();
    sy    = 4'($urandom_range(0, 15));
    for (int i = 0; i < words; i++) begin
      it.section_y     = sy;
      it.palette_size  = psize;
      it.section_start = (i == 0);
      r = $urandom_range(0, 99);
      // noise: drop or add a section start, switch size or height mid-section
      if (r < 4) begin
        it.section_start = ~it.section_start;
      end else if (r < 8) begin
        it.palette_size = pick_size();
      end else if (r < 10) begin
        it.section_y = 4'($urandom_range(0, 15));
      end
      it.packed_word = make_word(it.palette_size);
      push_word(it, CHECK_PREDICT, NO_RES);
    end
  endtask

  task automatic run_phase(input int items);
    int n;
    int len;
    n = 0;
    while (n < items) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (len > items - n) begin
        len = items - n;
      end
      calm = ($urandom_range(0, 5) == 0);
      play_section(len);
      n += len;
    end
    calm = 1'b0;
  endtask

  // One width-5 word leaves the count off a multiple of 16, so the width-4
  // tail crosses the section end in the middle of a word.
  task automatic overrun_section();
    word_item_t  it;
    logic [12:0] tail_size;
    it.section_y     = 4'($urandom_range(0, 15));
    it.palette_size  = 13'($urandom_range(17, 32));
    it.section_start = 1'b1;
    it.packed_word   = make_word(it.palette_size);
    push_word(it, CHECK_PREDICT, NO_RES);
    tail_size        = 13'($urandom_range(1, 16));
    it.palette_size  = tail_size;
    it.section_start = 1'b0;
    repeat (258) begin
      it.packed_word = make_word(tail_size);
      push_word(it, CHECK_PREDICT, NO_RES);
    end
  endtask

  // Output stall pattern.
  initial begin
    int g;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_res = {m_tdata[25:0], m_tdata[33:26], m_tdata[59:34], m_tdata[71:60], m_tlast};
      if (pending_blocks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got x=%0d y=%0d z=%0d %s%0d last=%0b",
                 $time, seen_res.world_x, seen_res.world_y, seen_res.world_z, "index=",
                 seen_res.palette_index, seen_res.last);
      end else begin
        want_res = pending_blocks.pop_front();
        if (seen_res.world_x !== want_res.world_x || seen_res.world_y !== want_res.world_y ||
            seen_res.world_z !== want_res.world_z ||
            seen_res.palette_index !== want_res.palette_index ||
            seen_res.last !== want_res.last) begin
          mismatches++;
          $display("%0t: result mismatch: expected x=%0d y=%0d z=%0d index=%0d last=%0b",
                   $time, want_res.world_x, want_res.world_y, want_res.world_z,
                   want_res.palette_index, want_res.last);
          $display("%0t:                     got x=%0d y=%0d z=%0d index=%0d last=%0b",
                   $time, seen_res.world_x, seen_res.world_y, seen_res.world_z,
                   seen_res.palette_index, seen_res.last);
        end
      end
    end
  end

  // Watchdog: end the run once no transfer has happened for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("packed_palette_index_unpacker regression: fail");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{'{4'd0,  13'd2,    1'b1, 64'hFFFF_FFFF_FFFF_FFF1}, CHECK_SINGLE,
        '{26'sd0, 8'd0, 26'sd0, 12'd1, 1'b1}},
      // continues at entry 16: local z 1
      '{'{4'd0,  13'd2,    1'b0, 64'hFFFF_FFFF_FFFF_FFF0}, CHECK_SINGLE,
        '{26'sd0, 8'd0, 26'sd1, 12'd0, 1'b1}},
      '{'{4'd3,  13'd0,    1'b1, 64'h0000_0000_0000_0000}, CHECK_SILENT, NO_RES},
      '{'{4'd3,  13'd1,    1'b0, 64'hFFFF_FFFF_FFFF_FFFF}, CHECK_SILENT, NO_RES},
      '{'{4'd5,  13'd1,    1'b1, 64'hFFFF_FFFF_FFFF_FFF0}, CHECK_SINGLE,
        '{26'sd0, 8'd80, 26'sd0, 12'd0, 1'b1}},
      '{'{4'd3,  13'd3,    1'b1, 64'h3333_3333_3333_3333}, CHECK_SILENT, NO_RES},
      '{'{4'd15, 13'd4096, 1'b1, 64'h0000_0000_0000_0000}, CHECK_PREDICT, NO_RES},
      '{'{4'd15, 13'd4096, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF}, CHECK_PREDICT, NO_RES},
      '{'{4'd9,  13'd8191, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF}, CHECK_PREDICT, NO_RES},
      '{'{4'd10, 13'd4097, 1'b0, 64'hA5A5_5A5A_C3C3_3C3C}, CHECK_PREDICT, NO_RES},
      '{'{4'd0,  13'd16,   1'b1, 64'h0123_4567_89AB_CDEF}, CHECK_PREDICT, NO_RES},
      '{'{4'd12, 13'd8,    1'b0, 64'h7777_7777_7777_7777}, CHECK_PREDICT, NO_RES},
      '{'{4'd1,  13'd17,   1'b0, 64'hFEDC_BA98_7654_3210}, CHECK_PREDICT, NO_RES},
      '{'{4'd2,  13'd32,   1'b0, 64'h0842_1084_2108_4210}, CHECK_PREDICT, NO_RES},
      '{'{4'd4,  13'd33,   1'b1, 64'h1F3E_7CF9_F3E7_CF9F}, CHECK_PREDICT, NO_RES},
      '{'{4'd6,  13'd65,   1'b0, 64'h8102_0408_1020_4081}, CHECK_PREDICT, NO_RES},
      '{'{4'd7,  13'd129,  1'b0, 64'h8000_0000_0000_0001}, CHECK_PREDICT, NO_RES},
      '{'{4'd8,  13'd257,  1'b0, 64'h5555_5555_5555_5555}, CHECK_PREDICT, NO_RES},
      '{'{4'd11, 13'd513,  1'b0, 64'hAAAA_AAAA_AAAA_AAAA}, CHECK_PREDICT, NO_RES},
      '{'{4'd13, 13'd1025, 1'b0, 64'hDEAD_BEEF_CAFE_F00D}, CHECK_PREDICT, NO_RES},
      '{'{4'd14, 13'd2049, 1'b0, 64'h0FFF_07FF_0800_0001}, CHECK_PREDICT, NO_RES},
      '{'{4'd8,  13'd4096, 1'b1, 64'h0000_0FFF_FFF0_0000}, CHECK_PREDICT, NO_RES}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(dir_rows); i++) begin
      push_word(dir_rows[i].item, dir_rows[i].kind, dir_rows[i].res);
    end
    settle();

    set_chunk(22'h1FFFFF, 22'h200000);
    run_phase(6);
    settle();
    set_chunk(22'h200000, 22'h1FFFFF);
    run_phase(6);
    overrun_section();
    settle();
    set_chunk(22'h3FFFFF, 22'h000001);
    run_phase(6);
    settle();
    set_chunk(22'($urandom), 22'($urandom));
    run_phase(6);
    settle();
    set_chunk(22'h000000, 22'h3FFFFF);
    run_phase(6);
    settle();

    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("packed_palette_index_unpacker regression: pass");
    end else begin
      $display("packed_palette_index_unpacker regression: fail");
    end
    $finish;
  end

endmodule
